// ----- design/pbct_pkg.sv -----
// Package for the packed byte counter table.
// Holds sizes, operation and status codes, item types and controller/datapath structs.
// No dependencies.
`default_nettype none

package pbct_pkg;

  localparam int WORDS = 16;
  localparam int SLOTS = 4 * WORDS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  localparam logic [2:0] MODE_WRITE  = 3'd0;
  localparam logic [2:0] MODE_READ   = 3'd1;
  localparam logic [2:0] MODE_ADD    = 3'd2;
  localparam logic [2:0] MODE_CLEAR  = 3'd3;
  localparam logic [2:0] MODE_INSERT = 3'd4;
  localparam logic [2:0] MODE_REMOVE = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_NONE  = 2'd2;

  typedef struct packed {
    logic [2:0]        mode;
    logic [7:0]        slot_number;
    logic signed [7:0] operand_value;
  } req_t;

  typedef struct packed {
    logic signed [7:0] read_value;
    logic [1:0]        status;
    logic [6:0]        hit_slot;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic rd_first;
    logic rd_next;
    logic wr;
    logic fin;
    logic xfer;
  } cmd_t;

  typedef struct packed {
    logic is_rmw;
    logic is_scan;
    logic dvalid;
    logic found;
    logic last;
    logic addr_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- design/pbct_dp.sv -----
// Datapath of the packed byte counter table: item register, word memory with
// valid bits, lane update and search logic, result and output registers.
// Depends on pbct_pkg.
`default_nettype none

module pbct_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire pbct_pkg::req_t req,
  input  wire pbct_pkg::cmd_t cmd,
  output pbct_pkg::sts_t      sts,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output pbct_pkg::rsp_t      rsp
);

  localparam int AW = pbct_pkg::AW;

  pbct_pkg::req_t item;
  logic [31:0]    mem [pbct_pkg::WORDS];
  logic [pbct_pkg::WORDS-1:0] vld;
  logic [31:0]    rdata;
  logic           rdata_vld;
  logic [AW-1:0]  rd_idx;
  logic           rdv;
  logic [AW:0]    addr;
  pbct_pkg::rsp_t res;
  pbct_pkg::rsp_t res_next;

  logic [7:0]     s0;
  logic           in_range;
  logic           is_rmw;
  logic           is_scan;
  logic [AW-1:0]  rmw_word;
  logic [AW-1:0]  raddr;
  logic [31:0]    word;
  logic [31:0]    new_word;
  logic [7:0]     want;
  logic [3:0]     match;
  logic           found;
  logic [1:0]     scan_lane;
  logic [1:0]     lane_sel;
  logic [7:0]     old_byte;
  logic [7:0]     new_byte;
  logic [AW+2:0]  hit_full;
  logic           rd;

  always_comb begin
    s0       = item.slot_number - 8'd1;
    in_range = (item.slot_number != 8'd0) &&
               (32'(item.slot_number) <= 32'(pbct_pkg::SLOTS));
    is_rmw   = (item.mode inside {[pbct_pkg::MODE_WRITE:pbct_pkg::MODE_CLEAR]}) && in_range;
    is_scan  = item.mode inside {pbct_pkg::MODE_INSERT, pbct_pkg::MODE_REMOVE};
    rmw_word = AW'(s0 >> 2);
    rd       = cmd.rd_first | cmd.rd_next;
    raddr    = cmd.rd_first ? (is_rmw ? rmw_word : '0) : addr[AW-1:0];
  end

  always_comb begin
    word = rdata_vld ? rdata : '0;
    want = (item.mode == pbct_pkg::MODE_INSERT) ? 8'h00 : item.operand_value;
    for (int l = 0; l < 4; l++) begin
      match[l] = (word[8*l +: 8] == want);
    end
    found     = |match;
    scan_lane = 2'd0;
    for (int l = 3; l >= 0; l--) begin
      if (match[l]) begin
        scan_lane = 2'(l);
      end
    end
    lane_sel = is_scan ? scan_lane : s0[1:0];
    old_byte = word[8*lane_sel +: 8];
    case (item.mode)
      pbct_pkg::MODE_WRITE:  new_byte = item.operand_value;
      pbct_pkg::MODE_ADD:    new_byte = old_byte + item.operand_value;
      pbct_pkg::MODE_CLEAR:  new_byte = 8'h00;
      pbct_pkg::MODE_INSERT: new_byte = item.operand_value;
      pbct_pkg::MODE_REMOVE: new_byte = 8'h00;
      default:               new_byte = old_byte;
    endcase
    new_word = word;
    new_word[8*lane_sel +: 8] = new_byte;
    hit_full = {1'b0, rd_idx, scan_lane} + (AW+3)'(1);
  end

  always_comb begin
    res_next.read_value = (is_rmw && item.mode == pbct_pkg::MODE_READ) ? old_byte : 8'h00;
    if ((item.mode inside {[pbct_pkg::MODE_WRITE:pbct_pkg::MODE_CLEAR]}) && !in_range) begin
      res_next.status = pbct_pkg::ST_RANGE;
    end else if (is_scan && !found) begin
      res_next.status = pbct_pkg::ST_NONE;
    end else begin
      res_next.status = pbct_pkg::ST_OK;
    end
    res_next.hit_slot = (is_scan && found) ? 7'(hit_full) : 7'd0;
  end

  always_comb begin
    sts.is_rmw    = is_rmw;
    sts.is_scan   = is_scan;
    sts.dvalid    = rdv;
    sts.found     = found;
    sts.last      = (rd_idx == AW'(pbct_pkg::WORDS - 1));
    sts.addr_done = (addr == (AW+1)'(pbct_pkg::WORDS));
    sts.out_free  = !rsp_valid || !rsp_stall;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[rd_idx] <= new_word;
    end
    if (rd) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= req;
    end
    if (rd) begin
      rdata_vld <= vld[raddr];
      rd_idx    <= raddr;
      addr      <= {1'b0, raddr} + (AW+1)'(1);
    end
    if (cmd.fin) begin
      res <= res_next;
    end
    if (cmd.xfer) begin
      rsp <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      rdv       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rdv <= rd;
      if (cmd.wr) begin
        vld[rd_idx] <= 1'b1;
      end
      if (cmd.xfer) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/pbct_ctrl.sv -----
// Controller of the packed byte counter table: sequences decode, word access,
// search and result hand-off.
// Depends on pbct_pkg.
`default_nettype none

module pbct_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire pbct_pkg::sts_t sts,
  output pbct_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_RMW  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.is_rmw) begin
          cmd.rd_first = 1'b1;
          state_next   = S_RMW;
        end else if (sts.is_scan) begin
          cmd.rd_first = 1'b1;
          state_next   = S_SCAN;
        end else begin
          cmd.fin    = 1'b1;
          state_next = S_DONE;
        end
      end
      S_RMW: begin
        cmd.wr     = 1'b1;
        cmd.fin    = 1'b1;
        state_next = S_DONE;
      end
      S_SCAN: begin
        if (sts.dvalid && sts.found) begin
          cmd.wr     = 1'b1;
          cmd.fin    = 1'b1;
          state_next = S_DONE;
        end else if (sts.dvalid && sts.last) begin
          cmd.fin    = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.rd_next = !sts.addr_done;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.xfer   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/packed_byte_counter_table.sv -----
// Top level of the packed byte counter table.
// Depends on pbct_pkg, pbct_ctrl and pbct_dp.
//
// The table holds WORDS 32-bit words of four signed byte counters each (slot 1 is
// byte 0 of word 0), all zero after reset; a zero slot is empty. Each request item
// writes, reads, adds to or clears one slot, or inserts a value into the first
// empty slot, or clears the first slot equal to a value, and yields one response
// item. Slot operations go through decode, one read-modify-write of the word
// memory and hand-off; an out-of-range slot or an unused mode skips the memory.
// Insert and remove search one word per cycle through the single-port word
// memory from word 0 and stop at the first hit or after the last word. While
// the response register stays stalled, the hand-off waits. A new request is
// taken while the previous response still waits in the output register.
`default_nettype none

module packed_byte_counter_table (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire pbct_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output pbct_pkg::rsp_t      rsp
);

  pbct_pkg::cmd_t cmd;
  pbct_pkg::sts_t sts;

  pbct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pbct_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// ----- design/pbct_check.sv -----
// Port checker for the packed byte counter table, bound to the top level.
// Depends on pbct_pkg.
`default_nettype none

module pbct_check (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_stall,
  input wire pbct_pkg::req_t req,
  input wire logic           rsp_valid,
  input wire logic           rsp_stall,
  input wire pbct_pkg::rsp_t rsp
);

  logic [1:0] pending;
  logic       req_acc;
  logic       rsp_acc;

  assign req_acc = req_valid && !req_stall;
  assign rsp_acc = rsp_valid && !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else begin
      pending <= pending + 2'(req_acc) - 2'(rsp_acc);
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("response dropped while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    rsp_acc |-> pending != 2'd0)
    else $error("response item without a request item");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending <= 2'd2)
    else $error("more than two items in flight");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != pbct_pkg::ST_OK |-> rsp.read_value == 8'sd0 &&
      rsp.hit_slot == 7'd0)
    else $error("error response carries data");

  a_hit_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.hit_slot != 7'd0 |-> rsp.status == pbct_pkg::ST_OK &&
      rsp.read_value == 8'sd0)
    else $error("bad hit response");

endmodule

bind packed_byte_counter_table pbct_check u_check (.*);

`default_nettype wire
